### rtl/dms_pkg.sv
// shared types, constants and base encoding for the degenerate motif scanner
package dms_pkg;

    localparam int MAX_MOTIF_DEF     = 16;
    localparam int POSITION_BITS_DEF = 32;
    localparam int MASK_SLOTS        = 16;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_MASKS        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_LENGTH       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_MISMATCHES = 2'd2;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_G = 8'h67;
    localparam logic [7:0] CHAR_T = 8'h74;

    localparam logic [3:0] CODE_A    = 4'b0001;
    localparam logic [3:0] CODE_C    = 4'b0010;
    localparam logic [3:0] CODE_G    = 4'b0100;
    localparam logic [3:0] CODE_T    = 4'b1000;
    localparam logic [3:0] CODE_NONE = 4'b0000;

    typedef struct packed {
        logic [7:0] base_char;
        logic       first_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic [31:0] start_position;
        logic [4:0]  mismatch_count;
    } t_out_item;

    // one-hot base code, anything but lower-case acgt matches nothing
    function automatic logic [3:0] base_code(input logic [7:0] ch);
        logic [3:0] code;
        case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

### rtl/degenerate_motif_scanner.sv
// degenerate motif scanner: iupac motif search with mismatches over a base stream
// path: a base is registered into the window, a hit then into the result register
// throughput: one base per cycle unless o_stall; the per-position mask compare and
//   the mismatch popcount sit between the window registers and the result register
// reset: synchronous active low; clears window fill, position, pipeline valids and the
//   configuration (masks 0, length 1, allowed mismatches 0)
module degenerate_motif_scanner #(
    parameter int MAX_MOTIF     = dms_pkg::MAX_MOTIF_DEF,
    parameter int POSITION_BITS = dms_pkg::POSITION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  dms_pkg::t_in_item            i_in_item,
    output logic                         o_valid,
    input  logic                         i_stall,
    output dms_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dms_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]                  i_cfg_data
);

    localparam int CAP       = (MAX_MOTIF < dms_pkg::MASK_SLOTS) ? MAX_MOTIF
                                                                  : dms_pkg::MASK_SLOTS;
    localparam int WIN_IDX_W = $clog2(MAX_MOTIF);
    localparam int FILL_W    = $clog2(MAX_MOTIF + 1);
    localparam logic [FILL_W-1:0]        FILL_MAX = FILL_W'(MAX_MOTIF);
    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;

    // configuration
    logic [63:0] r_motif_masks;
    logic [4:0]  r_motif_length;
    logic [4:0]  r_allowed;

    // sequence state
    logic [3:0]               r_window [MAX_MOTIF];
    logic [FILL_W-1:0]        r_fill;
    logic [POSITION_BITS-1:0] r_index;

    // compare stage
    logic                     r_s1_valid;
    logic [POSITION_BITS-1:0] r_s1_cur;

    // result register
    logic                r_out_valid;
    dms_pkg::t_out_item  r_out_item;

    logic                     in_accept;
    logic                     s1_adv;
    logic                     out_free;
    logic [FILL_W-1:0]        fill_base;
    logic [POSITION_BITS-1:0] index_base;
    logic [4:0]               len;
    logic [4:0]               miss;
    logic                     hit;
    logic [POSITION_BITS-1:0] start_full;
    logic [FILL_W-1:0]        n_fill;
    logic [POSITION_BITS-1:0] n_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_masks  <= '0;
            r_motif_length <= 5'd1;
            r_allowed      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dms_pkg::CFG_MOTIF_MASKS:        r_motif_masks  <= i_cfg_data;
                dms_pkg::CFG_MOTIF_LENGTH:       r_motif_length <= i_cfg_data[4:0];
                dms_pkg::CFG_ALLOWED_MISMATCHES: r_allowed      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free  = !r_out_valid || !i_stall;
    assign s1_adv    = r_s1_valid && (out_free || !hit);
    assign o_stall   = r_s1_valid && !s1_adv;
    assign in_accept = i_valid && !o_stall;

    // fill and position update
    always_comb begin
        fill_base  = i_in_item.first_of_sequence ? '0 : r_fill;
        index_base = i_in_item.first_of_sequence ? '0 : r_index;
        n_fill     = (fill_base < FILL_MAX) ? fill_base + FILL_W'(1) : fill_base;
        n_index    = (index_base < POS_MAX) ? index_base + POSITION_BITS'(1) : index_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_index    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_fill  <= n_fill;
                r_index <= n_index;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // entries past the fill count never affect a hit, so no clearing
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int i = MAX_MOTIF - 1; i > 0; i--) begin
                r_window[i] <= r_window[i-1];
            end
            r_window[0] <= dms_pkg::base_code(i_in_item.base_char);
            r_s1_cur    <= index_base;
        end
    end

    // length in use, clamped to one .. cap
    always_comb begin
        if (r_motif_length == 5'd0) begin
            len = 5'd1;
        end else if (int'(r_motif_length) > CAP) begin
            len = 5'(CAP);
        end else begin
            len = r_motif_length;
        end
    end

    // window always reflects the base in the compare stage
    always_comb begin
        int idx;
        miss = '0;
        for (int p = 0; p < CAP; p++) begin
            idx = int'(len) - 1 - p;
            if (p < int'(len)) begin
                if ((r_window[WIN_IDX_W'(idx)] & r_motif_masks[4*p +: 4]) == 4'd0) begin
                    miss = miss + 5'd1;
                end
            end
        end
    end

    assign hit        = (int'(r_fill) >= int'(len)) && (miss <= r_allowed);
    assign start_full = r_s1_cur - POSITION_BITS'(len - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && hit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && hit && out_free) begin
            r_out_item.start_position <= 32'(start_full);
            r_out_item.mismatch_count <= miss;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out_item;

endmodule
